[sv/lss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

	// Field and arithmetic widths
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int THR_W  = 40;
	localparam logic [THR_W-1:0] THR_RESET = 40'd42950;

	// Products are exact, the cross differences gain one bit
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = PROD_W + 1;
	// Magnitude of a determinant or numerator; input range keeps it below 2^(PROD_W-1)
	localparam int MAG_W  = PROD_W;

	// Quotient window and the dividend bits that lie above it
	localparam int Q_W        = DATA_W;
	localparam int SHIFT_W    = Q_W - FRAC_W;
	localparam int HI_W       = MAG_W - SHIFT_W;
	localparam int DIV_STAGES = Q_W;

	// Queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Clip bounds as magnitudes
	localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

	// One classified system, ready for division
	typedef struct packed {
		logic             solved;
		logic             neg0;
		logic             neg1;
		logic [MAG_W-1:0] d_mag;
		logic [MAG_W-1:0] n0_mag;
		logic [MAG_W-1:0] n1_mag;
	} sys_t;

endpackage

`default_nettype wire

[sv/lss_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lss_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [lss_pkg::DATA_W-1:0] a00;
	logic signed [lss_pkg::DATA_W-1:0] a01;
	logic signed [lss_pkg::DATA_W-1:0] a10;
	logic signed [lss_pkg::DATA_W-1:0] a11;
	logic signed [lss_pkg::DATA_W-1:0] b0;
	logic signed [lss_pkg::DATA_W-1:0] b1;

	modport source (output valid, a00, a01, a10, a11, b0, b1, input ready);
	modport sink (input valid, a00, a01, a10, a11, b0, b1, output ready);
endinterface

`default_nettype wire

[sv/lss_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lss_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [lss_pkg::DATA_W-1:0] x0;
	logic signed [lss_pkg::DATA_W-1:0] x1;
	logic                              solved;
	logic                              saturated;

	modport source (output valid, x0, x1, solved, saturated, input ready);
	modport sink (input valid, x0, x1, solved, saturated, output ready);
endinterface

`default_nettype wire

[sv/linear_solve_2x2_unit.sv]
// Solves A*x = b for a 2x2 system in signed Q16.16 by Cramer's rule, one system per
// word on sys, one result word on sol. The determinant and numerators are exact in Q32.32;
// a system whose determinant is zero or smaller in magnitude than det_threshold (cfg_wdata,
// written with cfg_we, reset 42950, about 1e-5) returns solved = 0 with zero outputs.
// Otherwise each quotient is truncated toward zero and clipped to the 32-bit signed range,
// with saturated set when either one clips. The block takes one word per cycle until a held output
// backs up the queue and the front: the front (three stages of multiply, subtract and classify)
// feeds a four-word queue, and the back is a restoring divider pair with one quotient bit per
// stage, 32 steps after a setup stage, followed by the output register. A held output freezes
// the back while the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module linear_solve_2x2_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	lss_in_if.sink                    sys,
	lss_out_if.source                 sol,
	input  logic                      cfg_we,
	input  logic [lss_pkg::THR_W-1:0] cfg_wdata
);

	logic [lss_pkg::THR_W-1:0] thr_q;

	logic          f_vld, f_rdy;
	lss_pkg::sys_t f_data;
	logic          b_vld, b_take;
	lss_pkg::sys_t b_data;

	// Hold the determinant threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= lss_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	lss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sys      (sys),
		.thr      (thr_q),
		.out_vld  (f_vld),
		.out_data (f_data),
		.out_rdy  (f_rdy)
	);

	lss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (f_vld),
		.push_data (f_data),
		.push_rdy  (f_rdy),
		.pop_vld   (b_vld),
		.pop_data  (b_data),
		.pop_en    (b_take)
	);

	lss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (b_vld),
		.in_data (b_data),
		.in_take (b_take),
		.sol     (sol)
	);

endmodule

`default_nettype wire

[sv/lss_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_front (
	input  logic                       clk,
	input  logic                       arst_n,
	lss_in_if.sink                     sys,
	input  logic [lss_pkg::THR_W-1:0]  thr,
	output logic                       out_vld,
	output lss_pkg::sys_t              out_data,
	input  logic                       out_rdy
);

	// Magnitude of a cross difference
	function automatic logic [lss_pkg::MAG_W-1:0] mag_of(input logic [lss_pkg::SUM_W-1:0] v);
		logic [lss_pkg::SUM_W-1:0] a;
		a = v[lss_pkg::SUM_W-1] ? (~v + 1'b1) : v;
		return a[lss_pkg::MAG_W-1:0];
	endfunction

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	logic signed [lss_pkg::PROD_W-1:0] p_a00a11_s1, p_a01a10_s1;
	logic signed [lss_pkg::PROD_W-1:0] p_a11b0_s1, p_a01b1_s1;
	logic signed [lss_pkg::PROD_W-1:0] p_a00b1_s1, p_a10b0_s1;

	logic [lss_pkg::SUM_W-1:0] det_s2, n0_s2, n1_s2;

	logic signed [lss_pkg::SUM_W:0] det_x, thr_x, det_plus_thr;
	logic                           solvable;
	lss_pkg::sys_t                  entry_s3;

	// Stall each stage only when the one after it is held
	assign en3       = !vld_s3 || out_rdy;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign sys.ready = en1;

	assign out_vld  = vld_s3;
	assign out_data = entry_s3;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= sys.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: six signed products
	always_ff @(posedge clk) begin
		if (en1) begin
			p_a00a11_s1 <= sys.a00 * sys.a11;
			p_a01a10_s1 <= sys.a01 * sys.a10;
			p_a11b0_s1  <= sys.a11 * sys.b0;
			p_a01b1_s1  <= sys.a01 * sys.b1;
			p_a00b1_s1  <= sys.a00 * sys.b1;
			p_a10b0_s1  <= sys.a10 * sys.b0;
		end
	end

	// Stage 2: determinant and both numerators at full width
	always_ff @(posedge clk) begin
		if (en2) begin
			det_s2 <= {p_a00a11_s1[lss_pkg::PROD_W-1], p_a00a11_s1}
			        - {p_a01a10_s1[lss_pkg::PROD_W-1], p_a01a10_s1};
			n0_s2  <= {p_a11b0_s1[lss_pkg::PROD_W-1], p_a11b0_s1}
			        - {p_a01b1_s1[lss_pkg::PROD_W-1], p_a01b1_s1};
			n1_s2  <= {p_a00b1_s1[lss_pkg::PROD_W-1], p_a00b1_s1}
			        - {p_a10b0_s1[lss_pkg::PROD_W-1], p_a10b0_s1};
		end
	end

	// Classify: |det| >= thr is det >= thr or det + thr <= 0; a zero determinant never passes
	assign det_x        = {det_s2[lss_pkg::SUM_W-1], det_s2};
	assign thr_x        = {{(lss_pkg::SUM_W + 1 - lss_pkg::THR_W){1'b0}}, thr};
	assign det_plus_thr = det_x + thr_x;
	assign solvable     = (det_s2 != '0)
	                   && ((det_x >= thr_x) || det_plus_thr[lss_pkg::SUM_W] || (det_plus_thr == '0));

	// Stage 3: signs, magnitudes and verdict
	always_ff @(posedge clk) begin
		if (en3) begin
			entry_s3.solved <= solvable;
			entry_s3.neg0   <= n0_s2[lss_pkg::SUM_W-1] ^ det_s2[lss_pkg::SUM_W-1];
			entry_s3.neg1   <= n1_s2[lss_pkg::SUM_W-1] ^ det_s2[lss_pkg::SUM_W-1];
			entry_s3.d_mag  <= mag_of(det_s2);
			entry_s3.n0_mag <= mag_of(n0_s2);
			entry_s3.n1_mag <= mag_of(n1_s2);
		end
	end

endmodule

`default_nettype wire

[sv/lss_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_vld,
	input  lss_pkg::sys_t push_data,
	output logic          push_rdy,
	output logic          pop_vld,
	output lss_pkg::sys_t pop_data,
	input  logic          pop_en
);

	lss_pkg::sys_t                mem_q [lss_pkg::QUEUE_DEPTH];
	logic [lss_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [lss_pkg::QPTR_W:0]     cnt_q;
	logic                         push, pop;

	assign push_rdy = cnt_q != (lss_pkg::QPTR_W + 1)'(lss_pkg::QUEUE_DEPTH);
	assign pop_vld  = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push     = push_vld && push_rdy;
	assign pop      = pop_vld && pop_en;

	// Track pointers and fill level; pointers wrap at the power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

[sv/lss_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  lss_pkg::sys_t in_data,
	output logic          in_take,
	lss_out_if.source     sol
);

	localparam int N  = lss_pkg::DIV_STAGES;
	localparam int MW = lss_pkg::MAG_W;
	localparam int QW = lss_pkg::Q_W;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	function automatic logic [MW+QW-1:0] div_step(
		input logic [MW-1:0] rem,
		input logic [QW-1:0] lq,
		input logic [MW-1:0] d
	);
		logic [MW:0]   t;
		logic [MW+1:0] diff;
		logic          ge;
		logic [MW-1:0] rem_n;
		t     = {rem, lq[QW-1]};
		diff  = {1'b0, t} - {2'b00, d};
		ge    = !diff[MW+1];
		rem_n = ge ? diff[MW-1:0] : t[MW-1:0];
		return {rem_n, lq[QW-2:0], ge};
	endfunction

	// Clip, sign and report clipping: returns {sat, value}
	function automatic logic [QW:0] finish(
		input logic [QW-1:0] q,
		input logic          ovf,
		input logic          neg
	);
		logic [QW-1:0] lim;
		logic [QW-1:0] mag;
		logic          sat;
		lim = neg ? lss_pkg::NEG_LIMIT : lss_pkg::POS_LIMIT;
		sat = ovf || (q > lim);
		mag = sat ? lim : q;
		return {sat, (neg ? (~mag + 1'b1) : mag)};
	endfunction

	logic adv;

	// Divider pipeline, indexed by stage: 0 is the setup stage, N the last step
	logic [MW-1:0] d_s    [N+1];
	logic [MW-1:0] rem0_s [N+1];
	logic [MW-1:0] rem1_s [N+1];
	logic [QW-1:0] lq0_s  [N+1];
	logic [QW-1:0] lq1_s  [N+1];
	logic          ovf0_s [N+1];
	logic          ovf1_s [N+1];
	logic          neg0_s [N+1];
	logic          neg1_s [N+1];
	logic          slv_s  [N+1];
	logic          vld_s  [N+1];

	logic [MW+QW-1:0] step0 [1:N];
	logic [MW+QW-1:0] step1 [1:N];

	logic [lss_pkg::HI_W-1:0] hi0, hi1;
	logic [MW-1:0]            hi0_x, hi1_x;
	logic                     ovf0, ovf1;

	logic [QW:0] fin0, fin1;

	logic                              vld_q;
	logic signed [lss_pkg::DATA_W-1:0] x0_q, x1_q;
	logic                              solved_q, sat_q;

	// Whole back end moves together unless the result is held
	assign adv     = !vld_q || sol.ready;
	assign in_take = adv;

	assign sol.valid     = vld_q;
	assign sol.x0        = x0_q;
	assign sol.x1        = x1_q;
	assign sol.solved    = solved_q;
	assign sol.saturated = sat_q;

	// Setup: quotient reaches 2^Q_W when the part above the window already holds the divisor
	assign hi0   = in_data.n0_mag[MW-1:lss_pkg::SHIFT_W];
	assign hi1   = in_data.n1_mag[MW-1:lss_pkg::SHIFT_W];
	assign hi0_x = {{lss_pkg::SHIFT_W{1'b0}}, hi0};
	assign hi1_x = {{lss_pkg::SHIFT_W{1'b0}}, hi1};
	assign ovf0  = hi0_x >= in_data.d_mag;
	assign ovf1  = hi1_x >= in_data.d_mag;

	// Steps of both dividers
	always_comb begin
		for (int k = 1; k <= N; k++) begin
			step0[k] = div_step(rem0_s[k-1], lq0_s[k-1], d_s[k-1]);
			step1[k] = div_step(rem1_s[k-1], lq1_s[k-1], d_s[k-1]);
		end
	end

	assign fin0 = finish(lq0_s[N], ovf0_s[N], neg0_s[N]);
	assign fin1 = finish(lq1_s[N], ovf1_s[N], neg1_s[N]);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) vld_s[k] <= 1'b0;
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= N; k++) vld_s[k] <= vld_s[k-1];
			vld_q <= vld_s[N];
		end
	end

	// Load setup stage and advance the division steps
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0]    <= in_data.d_mag;
			rem0_s[0] <= ovf0 ? '0 : hi0_x;
			rem1_s[0] <= ovf1 ? '0 : hi1_x;
			lq0_s[0]  <= {in_data.n0_mag[lss_pkg::SHIFT_W-1:0], {lss_pkg::FRAC_W{1'b0}}};
			lq1_s[0]  <= {in_data.n1_mag[lss_pkg::SHIFT_W-1:0], {lss_pkg::FRAC_W{1'b0}}};
			ovf0_s[0] <= ovf0;
			ovf1_s[0] <= ovf1;
			neg0_s[0] <= in_data.neg0;
			neg1_s[0] <= in_data.neg1;
			slv_s[0]  <= in_data.solved;
			for (int k = 1; k <= N; k++) begin
				d_s[k]                <= d_s[k-1];
				{rem0_s[k], lq0_s[k]} <= step0[k];
				{rem1_s[k], lq1_s[k]} <= step1[k];
				ovf0_s[k]             <= ovf0_s[k-1];
				ovf1_s[k]             <= ovf1_s[k-1];
				neg0_s[k]             <= neg0_s[k-1];
				neg1_s[k]             <= neg1_s[k-1];
				slv_s[k]              <= slv_s[k-1];
			end
		end
	end

	// Output register: clipped quotients, or zeros for an unsolved system
	always_ff @(posedge clk) begin
		if (adv) begin
			solved_q <= slv_s[N];
			if (slv_s[N]) begin
				x0_q  <= fin0[QW-1:0];
				x1_q  <= fin1[QW-1:0];
				sat_q <= fin0[QW] || fin1[QW];
			end else begin
				x0_q  <= '0;
				x1_q  <= '0;
				sat_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[sv/lss_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              sol_valid,
	input logic                              sol_ready,
	input logic signed [lss_pkg::DATA_W-1:0] x0,
	input logic signed [lss_pkg::DATA_W-1:0] x1,
	input logic                              solved,
	input logic                              saturated
);

	// No result shows while reset is held
	a_quiet_in_reset: assert property (@(posedge clk) !arst_n |-> !sol_valid)
		else $error("result word valid during reset");

	// An unsolved system carries zero outputs and no clip flag
	a_unsolved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && !solved |-> (x0 == '0) && (x1 == '0) && !saturated)
		else $error("unsolved result with nonzero fields");

	// Clipping is only reported for a solved system
	a_sat_needs_solved: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && saturated |-> solved)
		else $error("saturated set on unsolved result");

	// A held result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && !sol_ready |=> sol_valid && $stable(x0) && $stable(x1)
		&& $stable(solved) && $stable(saturated))
		else $error("result word changed while held");

endmodule

bind linear_solve_2x2_unit lss_checker u_lss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.sol_valid (sol.valid),
	.sol_ready (sol.ready),
	.x0        (sol.x0),
	.x1        (sol.x1),
	.solved    (sol.solved),
	.saturated (sol.saturated)
);

`default_nettype wire

[tb/linear_solve_2x2_unit_test.sv]
`timescale 1ns / 1ps

module linear_solve_2x2_unit_test;

	// Q16.16 values used by the directed rows
	localparam logic signed [lss_pkg::DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [lss_pkg::DATA_W-1:0] Q_TWO   = 32'sh0002_0000;
	localparam logic signed [lss_pkg::DATA_W-1:0] Q_THREE = 32'sh0003_0000;
	localparam logic signed [lss_pkg::DATA_W-1:0] S_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [lss_pkg::DATA_W-1:0] S_MIN   = 32'sh8000_0000;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 48;
	localparam int PHASE_COUNT     = 6;
	localparam int WORDS_PER_PHASE = 300;

	typedef struct packed {
		logic signed [lss_pkg::DATA_W-1:0] a00;
		logic signed [lss_pkg::DATA_W-1:0] a01;
		logic signed [lss_pkg::DATA_W-1:0] a10;
		logic signed [lss_pkg::DATA_W-1:0] a11;
		logic signed [lss_pkg::DATA_W-1:0] b0;
		logic signed [lss_pkg::DATA_W-1:0] b1;
	} system_t;

	typedef struct packed {
		logic signed [lss_pkg::DATA_W-1:0] x0;
		logic signed [lss_pkg::DATA_W-1:0] x1;
		logic                              solved;
		logic                              saturated;
	} solution_t;

	typedef struct packed {
		system_t   sys;
		logic      typed;
		solution_t sol;
	} row_t;

	localparam solution_t NO_SOLUTION = '0;

	// Directed rows: a typed solution where it reads off directly, else the predictor
	localparam int DIRECTED_COUNT = 22;
	localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{'{0, 0, 0, 0, 0, 0}, 1'b1, NO_SOLUTION},
		'{'{Q_ONE, 0, 0, Q_ONE, Q_ONE, Q_TWO}, 1'b1, '{Q_ONE, Q_TWO, 1'b1, 1'b0}},
		'{'{Q_ONE, 0, 0, Q_ONE, S_MAX, S_MIN}, 1'b1, '{S_MAX, S_MIN, 1'b1, 1'b0}},
		'{'{1, 0, 0, 1, Q_ONE, Q_ONE}, 1'b1, NO_SOLUTION},
		'{'{32'sd42949, 0, 0, 1, Q_ONE, Q_ONE}, 1'b1, NO_SOLUTION},
		'{'{32'sd42950, 0, 0, 1, Q_ONE, Q_ONE}, 1'b0, NO_SOLUTION},
		'{'{-32'sd42950, 0, 0, 1, Q_ONE, -Q_ONE}, 1'b0, NO_SOLUTION},
		'{'{32'sh100, 0, 0, 32'sh100, S_MAX, S_MIN}, 1'b1, '{S_MAX, S_MIN, 1'b1, 1'b1}},
		'{'{32'sh100, 0, 0, 32'sh100, S_MIN, S_MAX}, 1'b1, '{S_MIN, S_MAX, 1'b1, 1'b1}},
		'{'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1, NO_SOLUTION},
		'{'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1'b1, NO_SOLUTION},
		'{'{S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN}, 1'b0, NO_SOLUTION},
		'{'{S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX}, 1'b0, NO_SOLUTION},
		'{'{S_MIN, 0, 0, S_MIN, S_MIN, S_MAX}, 1'b0, NO_SOLUTION},
		'{'{S_MIN, S_MAX, S_MAX, S_MAX, Q_ONE, -Q_ONE}, 1'b0, NO_SOLUTION},
		'{'{S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX}, 1'b1, NO_SOLUTION},
		'{'{-Q_ONE, 0, 0, -Q_ONE, Q_ONE, -Q_ONE}, 1'b1, '{-Q_ONE, Q_ONE, 1'b1, 1'b0}},
		'{'{Q_THREE, 0, 0, Q_THREE, Q_ONE, -Q_ONE}, 1'b1,
			'{32'sh0000_5555, 32'shFFFF_AAAB, 1'b1, 1'b0}},
		'{'{0, Q_ONE, Q_ONE, 0, 0, 0}, 1'b1, '{0, 0, 1'b1, 1'b0}},
		'{'{0, Q_ONE, Q_ONE, 0, Q_ONE, Q_TWO}, 1'b1, '{Q_TWO, Q_ONE, 1'b1, 1'b0}},
		'{'{Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b1, NO_SOLUTION},
		'{'{32'shDEAD_BEEF, 32'sh1234_5678, 32'shCAFE_F00D, 32'sh0BAD_F00D,
			32'sh7654_3210, 32'sh8765_4321}, 1'b0, NO_SOLUTION}
	};

	localparam logic signed [lss_pkg::DATA_W-1:0] EXTREME_VALUES [7] = '{
		S_MIN, S_MAX, 0, 1, -1, Q_ONE, -Q_ONE
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lss_pkg::THR_W-1:0] cfg_wdata;

	lss_in_if  sys_ch ();
	lss_out_if sol_ch ();

	solution_t expected_solutions [$];
	logic [lss_pkg::THR_W-1:0] threshold = lss_pkg::THR_RESET;
	int error_count = 0;
	int send_calm = 0;
	int sink_calm = 0;
	int idle_cycles = 0;

	linear_solve_2x2_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sys       (sys_ch),
		.sol       (sol_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Exact p*q - r*s at full width
	function automatic logic signed [127:0] cross_diff(
		input logic signed [lss_pkg::DATA_W-1:0] p, q, r, s);
		logic signed [127:0] ep, eq, er, es;
		ep = p;
		eq = q;
		er = r;
		es = s;
		return ep * eq - er * es;
	endfunction

	// Truncated num * 2^FRAC_W / den, clipped to the signed field range
	function automatic logic [lss_pkg::DATA_W-1:0] clip_quotient(
		input logic signed [127:0] num, den, output logic clipped);
		logic neg;
		logic [127:0] nmag, dmag, quo, lim, res;
		neg = num[127] ^ den[127];
		nmag = num[127] ? -num : num;
		dmag = den[127] ? -den : den;
		quo = (nmag << lss_pkg::FRAC_W) / dmag;
		lim = (128'd1 << (lss_pkg::DATA_W - 1)) - (neg ? 128'd0 : 128'd1);
		clipped = quo > lim;
		if (clipped)
			quo = lim;
		res = neg ? -quo : quo;
		return res[lss_pkg::DATA_W-1:0];
	endfunction

	function automatic solution_t solve_system(input system_t s,
		input logic [lss_pkg::THR_W-1:0] thr);
		logic signed [127:0] det, n0, n1;
		logic [127:0] dmag;
		logic clip0, clip1;
		solution_t r;
		r = '0;
		det = cross_diff(s.a00, s.a11, s.a01, s.a10);
		dmag = det[127] ? -det : det;
		// A zero determinant never solves, whatever the threshold
		if (dmag != 0 && dmag >= {88'd0, thr}) begin
			n0 = cross_diff(s.a11, s.b0, s.a01, s.b1);
			n1 = cross_diff(s.a00, s.b1, s.a10, s.b0);
			r.x0 = clip_quotient(n0, det, clip0);
			r.x1 = clip_quotient(n1, det, clip1);
			r.solved = 1'b1;
			r.saturated = clip0 | clip1;
		end
		return r;
	endfunction

	// Draw a wait, with occasional runs of back-to-back words
	function automatic int pick_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic system_t make_system(input logic [lss_pkg::THR_W-1:0] thr);
		logic [lss_pkg::DATA_W-1:0] f [6];
		int mode;
		int jitter;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 6; k++)
			f[k] = $urandom();
		case (mode)
			4: begin
				// small values around a few units
				for (int k = 0; k < 6; k++)
					f[k] = 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
			end
			5: begin
				// equal rows: singular matrix
				f[2] = f[0];
				f[3] = f[1];
			end
			6: begin
				// determinant near the threshold, either sign
				jitter = $urandom_range(0, 4);
				if (thr < 40'h00_8000_0000) begin
					f[0] = thr[lss_pkg::DATA_W-1:0] + jitter - 2;
					f[3] = 1;
				end else begin
					f[0] = 32'(thr >> 9) + jitter - 2;
					f[3] = 512;
				end
				f[1] = 0;
				f[2] = 0;
				if ($urandom_range(0, 1) == 1)
					f[0] = -f[0];
			end
			7: begin
				for (int k = 0; k < 6; k++)
					f[k] = EXTREME_VALUES[$urandom_range(0, 6)];
			end
			8: begin
				// diagonal-heavy matrix, full-range right side
				f[0] = 32'($urandom_range(1, 32'h8_0000));
				f[3] = 32'($urandom_range(1, 32'h8_0000));
				if ($urandom_range(0, 1) == 1)
					f[0] = -f[0];
				if ($urandom_range(0, 1) == 1)
					f[3] = -f[3];
				f[1] = ($urandom_range(0, 1) == 1) ? 32'd0 : 32'($urandom_range(0, 32'hFFFF));
				f[2] = ($urandom_range(0, 1) == 1) ? 32'd0 : 32'($urandom_range(0, 32'hFFFF));
			end
			9: begin
				for (int k = 0; k < 6; k++)
					f[k] = $signed($urandom()) >>> $urandom_range(0, 31);
			end
			default: ;
		endcase
		return '{f[0], f[1], f[2], f[3], f[4], f[5]};
	endfunction

	task automatic report_error(input string msg);
		if (error_count < 10)
			$display("%s", msg);
		error_count++;
	endtask

	// Present one word after a gap and hold it until taken
	task automatic send_system(input system_t word, input solution_t want, input int gap);
		if (gap > 0) begin
			sys_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_solutions.push_back(want);
		sys_ch.valid <= 1'b1;
		sys_ch.a00 <= word.a00;
		sys_ch.a01 <= word.a01;
		sys_ch.a10 <= word.a10;
		sys_ch.a11 <= word.a11;
		sys_ch.b0 <= word.b0;
		sys_ch.b1 <= word.b1;
		@(posedge clk);
		while (!sys_ch.ready) @(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_solutions();
		sys_ch.valid <= 1'b0;
		while (expected_solutions.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [lss_pkg::THR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = value;
	endtask

	// Main stimulus
	initial begin : stimulus
		system_t word;
		solution_t want;
		logic [lss_pkg::THR_W-1:0] next_thr;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		sys_ch.valid <= 1'b0;
		sys_ch.a00 <= '0;
		sys_ch.a01 <= '0;
		sys_ch.a10 <= '0;
		sys_ch.a11 <= '0;
		sys_ch.b0 <= '0;
		sys_ch.b1 <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset threshold
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			want = DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].sol
				: solve_system(DIRECTED_ROWS[i].sys, threshold);
			send_system(DIRECTED_ROWS[i].sys, want, pick_wait(send_calm));
		end

		// Random words, one threshold per phase
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: next_thr = '0;
				1: next_thr = '1;
				2: next_thr = {8'($urandom_range(0, 255)), 32'($urandom())};
				3: next_thr = 40'd1;
				4: next_thr = lss_pkg::THR_RESET;
				default: next_thr = 40'($urandom_range(0, 32'h00FF_FFFF));
			endcase
			drain_solutions();
			write_threshold(next_thr);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				word = make_system(threshold);
				send_system(word, solve_system(word, threshold), pick_wait(send_calm));
			end
		end

		drain_solutions();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Result side: stall at random before taking each word
	initial begin : drive_ready
		int stall;
		sol_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = pick_wait(sink_calm);
			if (stall > 0) begin
				sol_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sol_ch.ready <= 1'b1;
			@(posedge clk);
			while (!sol_ch.valid) @(posedge clk);
		end
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin : check_solutions
		solution_t want;
		solution_t got;
		if (arst_n && sol_ch.valid && sol_ch.ready) begin
			got = '{sol_ch.x0, sol_ch.x1, sol_ch.solved, sol_ch.saturated};
			if (expected_solutions.size() == 0) begin
				report_error($sformatf("unexpected word x0=%h x1=%h solved=%b sat=%b",
					got.x0, got.x1, got.solved, got.saturated));
			end else begin
				want = expected_solutions.pop_front();
				if (got.x0 !== want.x0 || got.x1 !== want.x1
					|| got.solved !== want.solved || got.saturated !== want.saturated)
					report_error($sformatf(
						"mismatch: exp x0=%h x1=%h solved=%b sat=%b, got x0=%h x1=%h solved=%b sat=%b",
						want.x0, want.x1, want.solved, want.saturated,
						got.x0, got.x1, got.solved, got.saturated));
			end
		end
	end

	// Stop a run in which no word moves for too long
	always @(posedge clk) begin
		if ((sys_ch.valid && sys_ch.ready) || (sol_ch.valid && sol_ch.ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

endmodule

[filelist.f]
sv/lss_pkg.sv
sv/lss_in_if.sv
sv/lss_out_if.sv
sv/lss_front.sv
sv/lss_queue.sv
sv/lss_back.sv
sv/linear_solve_2x2_unit.sv
sv/lss_checker.sv
tb/linear_solve_2x2_unit_test.sv
